// ===== rtl/mpws_pkg.sv =====
// ----------------------------------------------------------------------------
// mpws_pkg
// shared types and constants for the multichannel pulse wave synth
// ----------------------------------------------------------------------------
package mpws_pkg;

  localparam int PHASE_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int DIV_LAT  = 4;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_FREQ = 2'd1,
    KIND_DUTY = 2'd2
  } kind_t;

endpackage

// ===== rtl/mpws_inc_div.sv =====
// ----------------------------------------------------------------------------
// mpws_inc_div
// pipelined phase increment: (freq << (32 - FRAC_BITS)) / SAMPLE_RATE by a
// constant reciprocal multiply with one correction step, DIV_LAT stages
// ----------------------------------------------------------------------------
module mpws_inc_div import mpws_pkg::*; #(
  parameter int SAMPLE_RATE = 44100,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [PHASE_W-1:0] freq,
  output logic [PHASE_W-1:0] inc
);

  localparam int SHIFT  = PHASE_W - FRAC_BITS;
  localparam int DIV_K  = 50;
  localparam int M_HALF = 19;
  localparam int PP_W   = PHASE_W + M_HALF;
  localparam int PROD_W = PHASE_W + 2 * M_HALF;
  localparam int QR_W   = PHASE_W + 18;
  localparam logic [63:0] RECIP = (64'd1 << DIV_K) / 64'(SAMPLE_RATE);
  localparam logic [M_HALF-1:0] RECIP_LO = RECIP[M_HALF-1:0];
  localparam logic [M_HALF-1:0] RECIP_HI = RECIP[2*M_HALF-1:M_HALF];

  logic [PP_W-1:0]    p_lo;
  logic [PP_W-1:0]    p_hi;
  logic [PHASE_W-1:0] f1;
  logic [PHASE_W-1:0] q0;
  logic [PHASE_W-1:0] f2;
  logic [PHASE_W-1:0] q1;
  logic [QR_W-1:0]    qr;
  logic [PHASE_W-1:0] f3;
  logic [PROD_W-1:0]  prod;
  logic [63:0]        rem;

  assign prod = PROD_W'(p_lo) + (PROD_W'(p_hi) << M_HALF);
  assign rem  = (64'(f3) << SHIFT) - 64'(qr);

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= PP_W'(freq) * PP_W'(RECIP_LO);
      p_hi <= PP_W'(freq) * PP_W'(RECIP_HI);
      f1   <= freq;
      q0   <= PHASE_W'(prod >> (DIV_K - SHIFT));
      f2   <= f1;
      qr   <= QR_W'(q0) * QR_W'(SAMPLE_RATE);
      q1   <= q0;
      f3   <= f2;
      inc  <= (rem >= 64'(SAMPLE_RATE)) ? q1 + PHASE_W'(1) : q1;
    end
  end

endmodule

// ===== rtl/multichannel_pulse_wave_synth_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_pulse_wave_synth_core
// mixes CHANNELS pulse oscillators with 32-bit phase accumulators into one
// signed 16-bit sample per tick item
// ----------------------------------------------------------------------------
// One item is accepted every cycle unless the input stalls. Every item, tick
// or write, runs through the same in-order pipeline: an input register, the
// DIV_LAT stage increment divider (a frequency write is turned into its phase
// increment there), a commit stage that updates the channel registers and
// phases, and the output register. A two-deep output register and skid stage
// keep input transfers going while a sample waits; the input stalls only when
// both hold a sample.
module multichannel_pulse_wave_synth_core import mpws_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_RATE = 44100,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // channel[1:0], value[33:2], zero pad
  input  logic [1:0]          s_axis_tuser,   // kind[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata    // sample[15:0]
);

  localparam logic [63:0] NYQ = 64'(SAMPLE_RATE / 2) << FRAC_BITS;
  localparam logic signed [SAMPLE_W-1:0] HI_PART = SAMPLE_W'(32767 / CHANNELS);
  localparam logic signed [SAMPLE_W-1:0] LO_PART = SAMPLE_W'(-32768 / CHANNELS);

  typedef struct packed {
    logic               vld;
    kind_t              kind;
    logic [1:0]         channel;
    logic               active;
    logic [PHASE_W-1:0] value;
  } ctl_t;

  logic               en;
  logic               in_vld;
  kind_t              in_kind;
  logic [1:0]         in_channel;
  logic [PHASE_W-1:0] in_value;
  logic               in_active;
  ctl_t               ctl [DIV_LAT];
  ctl_t               cm;
  logic [PHASE_W-1:0] inc;

  logic               chan_active [CHANNELS];
  logic [PHASE_W-1:0] chan_inc    [CHANNELS];
  logic [PHASE_W-1:0] chan_duty   [CHANNELS];
  logic [PHASE_W-1:0] phase       [CHANNELS];

  logic                       tk_vld;
  logic signed [SAMPLE_W-1:0] contrib [CHANNELS];
  logic signed [SAMPLE_W-1:0] sum;
  logic                       push;

  logic                out_vld;
  logic [SAMPLE_W-1:0] out_sample;
  logic                skid_vld;
  logic [SAMPLE_W-1:0] skid_sample;

  assign en            = !skid_vld;
  assign s_axis_tready = en;
  assign cm            = ctl[DIV_LAT-1];
  assign push          = en && tk_vld;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = out_sample;

  assign in_active = !in_value[PHASE_W-1] && (in_value != '0) && (64'(in_value) <= NYQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= s_axis_tvalid;
    end
    if (en) begin
      in_kind    <= kind_t'(s_axis_tuser);
      in_channel <= s_axis_tdata[1:0];
      in_value   <= s_axis_tdata[33:2];
    end
  end

  mpws_inc_div #(
    .SAMPLE_RATE (SAMPLE_RATE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_inc_div (
    .clk  (clk),
    .en   (en),
    .freq (in_value),
    .inc  (inc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        ctl[i] <= '0;
      end
    end else if (en) begin
      ctl[0] <= '{vld: in_vld, kind: in_kind, channel: in_channel,
                  active: in_active, value: in_value};
      for (int i = 1; i < DIV_LAT; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tk_vld <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_active[i] <= 1'b0;
        chan_duty[i]   <= '0;
        phase[i]       <= '0;
      end
    end else if (en) begin
      tk_vld <= cm.vld && (cm.kind == KIND_TICK);
      for (int i = 0; i < CHANNELS; i++) begin
        if (cm.vld && (32'(cm.channel) == i)) begin
          case (cm.kind)
            KIND_FREQ: begin
              chan_active[i] <= cm.active;
              chan_inc[i]    <= inc;
            end
            KIND_DUTY: begin
              chan_duty[i] <= cm.value;
            end
            default: begin
            end
          endcase
        end
        if (cm.vld && (cm.kind == KIND_TICK) && chan_active[i]) begin
          phase[i] <= phase[i] + chan_inc[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (!chan_active[i]) begin
          contrib[i] <= '0;
        end else if ($signed({1'b0, phase[i] >> FRAC_BITS}) <
                     $signed({chan_duty[i][PHASE_W-1], chan_duty[i]})) begin
          contrib[i] <= HI_PART;
        end else begin
          contrib[i] <= LO_PART;
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sum = sum + contrib[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (out_vld && m_axis_tready) begin
      if (skid_vld) begin
        out_sample <= skid_sample;
        out_vld    <= 1'b1;
        skid_vld   <= 1'b0;
      end else if (push) begin
        out_sample <= sum;
        out_vld    <= 1'b1;
      end else begin
        out_vld <= 1'b0;
      end
    end else if (!out_vld) begin
      if (push) begin
        out_sample <= sum;
        out_vld    <= 1'b1;
      end
    end else if (push) begin
      skid_sample <= sum;
      skid_vld    <= 1'b1;
    end
  end

endmodule
